// ----- src/ptbl_pkg.sv -----
// Shared types, constants and codes for the per-category token bucket limiter.
package ptbl_pkg;

  // Field widths
  localparam int CAT_W      = 6;
  localparam int TIME_W     = 48;
  localparam int TOK_W      = 10;
  localparam int CNT_W      = 32;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Stream words, padded to whole bytes
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  // Sizing defaults
  localparam int NUM_CATEGORIES_DEF = 64;
  localparam int QUEUE_DEPTH        = 4;

  // Refill arithmetic: elapsed * rate / 1000
  localparam int PROD_W      = TIME_W + TOK_W;
  // Products at or above 2**SMALL_W refill more than any bucket can take
  localparam int SMALL_W     = 21;
  localparam int RECIP_SHIFT = 31;
  localparam int RECIP_MW    = 22;
  localparam int RECIP_W     = SMALL_W + RECIP_MW;
  localparam int QUOT_W      = 12;
  localparam int MsPerSec    = 1000;
  localparam logic [RECIP_MW-1:0] RECIP_MUL = RECIP_MW'((64'd1 << RECIP_SHIFT) / MsPerSec);
  localparam logic [CNT_W-1:0]    CNT_MAX   = '1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PASS    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROP    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKENS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_RATE  = 2'd2;

  typedef struct packed {
    logic             limit_enable;
    logic [TOK_W-1:0] max_tokens;
    logic [TOK_W-1:0] refill_rate;
  } cfg_t;

  // One classified message waiting for the bucket engine
  typedef struct packed {
    logic [CAT_W-1:0]  cat;
    logic              bypass;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  // One bucket entry as stored in the bucket RAM
  typedef struct packed {
    logic              valid;
    logic [TOK_W-1:0]  tokens;
    logic [TIME_W-1:0] stamp;
    logic [CNT_W-1:0]  supp;
  } bucket_t;

  localparam int BUCKET_W = $bits(bucket_t);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CAT_W-1:0]  cat;
    logic [CNT_W-1:0]  count;
    logic              last;
  } result_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_MUL,
    B_RECIP,
    B_CORR,
    B_UPD,
    B_EMIT_SUM,
    B_EMIT_MSG
  } back_state_t;

endpackage

// ----- src/ptbl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module ptbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ptbl_front.sv -----
// Front end: accept message words, classify them and queue them for the bucket engine.
module ptbl_front #(
  parameter int NUM_CATEGORIES = ptbl_pkg::NUM_CATEGORIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ptbl_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                            in_tuser,
  input  ptbl_pkg::cfg_t                  cfg,
  input  logic                            clr_busy,
  input  logic                            q_pop,
  output ptbl_pkg::qhead_t                q_head
);
  import ptbl_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [12:0] NUM_L = 13'(NUM_CATEGORIES);

  item_t             queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  item_t             new_item;
  logic [CAT_W-1:0]  in_cat;

  // Classify the incoming word
  always_comb begin
    in_cat        = in_tdata[CAT_W-1:0];
    new_item.cat  = in_cat;
    new_item.now  = in_tdata[CAT_W+TIME_W-1:CAT_W];
    new_item.bypass = !cfg.limit_enable || !in_tuser || ({7'd0, in_cat} >= NUM_L);
  end

  // Hold off new words during the clearing pass or when the queue is full
  assign in_tready = !clr_busy && (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;

  assign q_head.valid = (cnt_r != '0);
  assign q_head.item  = queue_r[rd_ptr_r];

  // Advance queue pointers
  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the classified word
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_item;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != '0)
    else $error("queue popped while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ----- src/ptbl_back.sv -----
// Back end: clear the bucket store, run each queued message through its bucket, emit results.
module ptbl_back #(
  parameter int NUM_CATEGORIES = ptbl_pkg::NUM_CATEGORIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ptbl_pkg::cfg_t    cfg,
  input  ptbl_pkg::qhead_t  q_head,
  output logic              q_pop,
  output logic              clr_busy,
  input  logic              out_tready,
  output logic              out_valid,
  output ptbl_pkg::result_t out_res
);
  import ptbl_pkg::*;

  localparam int IDX_W = $clog2(NUM_CATEGORIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CATEGORIES - 1);

  back_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  result_t             out_r, out_nxt;
  logic                out_load;
  logic                slot_free;

  // Work registers for the item in flight
  item_t               cur_r;
  bucket_t             ent_r;
  logic                later_r;
  logic [TIME_W-1:0]   elapsed_r;
  logic [PROD_W-1:0]   prod_r;
  logic                big_r;
  logic [SMALL_W-1:0]  plo_r;
  logic [RECIP_W-1:0]  recip_r;
  logic [QUOT_W-1:0]   quot_r;
  logic [KIND_W-1:0]   fin_kind_r;
  logic [CNT_W-1:0]    sum_cnt_r;

  // RAM port
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [BUCKET_W-1:0] ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [BUCKET_W-1:0] ram_rdata;

  // Datapath terms
  bucket_t             rd_ent, ent_eff, ent_new;
  logic [QUOT_W-1:0]   q0;
  logic [RECIP_MW-1:0] q0_x1000;
  logic [RECIP_MW-1:0] rem;
  logic                refill_nz;
  logic [TOK_W+2:0]    tok_sum;
  logic [TOK_W-1:0]    tok_mid;
  logic [CNT_W-1:0]    supp_mid;
  logic                do_sum;
  logic [KIND_W-1:0]   upd_kind;

  ptbl_ram #(
    .WIDTH (BUCKET_W),
    .DEPTH (NUM_CATEGORIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = IDX_W'(q_head.item.cat);
  assign slot_free = !out_valid_r || out_tready;
  assign clr_busy  = (state_r == B_CLEAR);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // Fill an unused bucket on first touch, then measure elapsed time
  always_comb begin
    rd_ent  = bucket_t'(ram_rdata);
    ent_eff = rd_ent;
    if (!rd_ent.valid) begin
      ent_eff.valid  = 1'b1;
      ent_eff.tokens = cfg.max_tokens;
      ent_eff.stamp  = cur_r.now;
    end
  end

  // Correct the reciprocal quotient by one step
  always_comb begin
    q0       = recip_r[RECIP_W-1:RECIP_SHIFT];
    q0_x1000 = RECIP_MW'(q0) * RECIP_MW'(MsPerSec);
    rem      = RECIP_MW'(plo_r) - q0_x1000;
  end

  // Refill, summary decision and token take or drop count
  always_comb begin
    refill_nz = later_r && (big_r || (quot_r != '0));
    tok_sum   = (TOK_W+3)'(ent_r.tokens) + (TOK_W+3)'(quot_r);
    tok_mid   = ent_r.tokens;
    ent_new   = ent_r;
    if (refill_nz) begin
      tok_mid       = (big_r || tok_sum > (TOK_W+3)'(cfg.max_tokens)) ?
                      cfg.max_tokens : tok_sum[TOK_W-1:0];
      ent_new.stamp = cur_r.now;
    end
    do_sum   = refill_nz && (ent_r.supp != '0) && (tok_mid != '0);
    supp_mid = do_sum ? '0 : ent_r.supp;
    if (tok_mid != '0) begin
      ent_new.tokens = tok_mid - 1'b1;
      ent_new.supp   = supp_mid;
      upd_kind       = KIND_PASS;
    end else begin
      ent_new.tokens = '0;
      ent_new.supp   = (supp_mid == CNT_MAX) ? supp_mid : supp_mid + 1'b1;
      upd_kind       = KIND_DROP;
    end
  end

  // Next state, RAM write and result loading
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = IDX_W'(cur_r.cat);
    ram_wdata     = BUCKET_W'(ent_new);
    out_load      = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      B_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_LAST) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_head.valid) begin
          q_pop     = 1'b1;
          state_nxt = q_head.item.bypass ? B_EMIT_MSG : B_READ;
        end
      end
      B_READ:  state_nxt = B_MUL;
      B_MUL:   state_nxt = B_RECIP;
      B_RECIP: state_nxt = B_CORR;
      B_CORR:  state_nxt = B_UPD;
      B_UPD: begin
        ram_we    = 1'b1;
        state_nxt = do_sum ? B_EMIT_SUM : B_EMIT_MSG;
      end
      B_EMIT_SUM: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_nxt.kind  = KIND_SUMMARY;
          out_nxt.cat   = cur_r.cat;
          out_nxt.count = sum_cnt_r;
          out_nxt.last  = 1'b0;
          state_nxt     = B_EMIT_MSG;
        end
      end
      B_EMIT_MSG: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_nxt.kind  = fin_kind_r;
          out_nxt.cat   = cur_r.cat;
          out_nxt.count = '0;
          out_nxt.last  = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Work registers, one stage per state
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
    unique case (state_r)
      B_IDLE: begin
        cur_r      <= q_head.item;
        fin_kind_r <= KIND_PASS;
      end
      B_READ: begin
        ent_r     <= ent_eff;
        later_r   <= cur_r.now > ent_eff.stamp;
        elapsed_r <= cur_r.now - ent_eff.stamp;
      end
      B_MUL: begin
        prod_r <= PROD_W'(elapsed_r) * PROD_W'(cfg.refill_rate);
      end
      B_RECIP: begin
        big_r   <= |prod_r[PROD_W-1:SMALL_W];
        plo_r   <= prod_r[SMALL_W-1:0];
        recip_r <= RECIP_W'(prod_r[SMALL_W-1:0]) * RECIP_W'(RECIP_MUL);
      end
      B_CORR: begin
        quot_r <= (rem >= RECIP_MW'(MsPerSec)) ? q0 + 1'b1 : q0;
      end
      B_UPD: begin
        fin_kind_r <= upd_kind;
        sum_cnt_r  <= ent_r.supp;
      end
      default: begin
      end
    endcase
  end

  a_quot_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_UPD && !big_r) |->
      (24'(quot_r) * 24'(MsPerSec) <= 24'(plo_r)) &&
      (24'(plo_r) < 24'(quot_r) * 24'(MsPerSec) + 24'(MsPerSec)))
    else $error("refill quotient off by more than the correction");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == B_CLEAR || state_r == B_UPD))
    else $error("bucket store written outside clear or update");

  a_sum_then_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EMIT_SUM && slot_free) |=> (state_r == B_EMIT_MSG && out_valid_r))
    else $error("summary not followed by its message result");

endmodule

// ----- src/per_category_token_bucket_limiter.sv -----
// Top level: configuration registers, stream packing and the front and back ends.
//
//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid / in_tready  | tdata: category_id, now_ms; tuser: has_category
//  out_    | master    | out_tvalid/out_tready  | tdata: out_category, suppressed_count;
//          |           |                        | tuser: kind; tlast: last
//  cfg_    | slave     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A message that bypasses limiting goes from idle straight to emitting its result;
// a limited message passes through the bucket RAM read, the refill multiply, the
// reciprocal divide by 1000 and the bucket update, with a summary word first when due.
// After reset a clearing pass writes every bucket with in_tready low. A four-word
// queue lets input words arrive while the back end works or while the output
// register waits on out_tready.
module per_category_token_bucket_limiter #(
  parameter int NUM_CATEGORIES = ptbl_pkg::NUM_CATEGORIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [5:0] category_id, [53:6] now_ms, [55:54] zero
  input  logic [ptbl_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] has_category
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [5:0] out_category, [37:6] suppressed_count, [39:38] zero
  output logic [ptbl_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [1:0] kind
  output logic [ptbl_pkg::KIND_W-1:0]      out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ptbl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptbl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ptbl_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  qhead_t  q_head;
  logic    q_pop;
  logic    clr_busy;
  result_t res;

  assign cfg_ready = 1'b1;

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LIMIT_ENABLE: cfg_nxt.limit_enable = cfg_data[0];
        CFG_MAX_TOKENS:   cfg_nxt.max_tokens   = cfg_data[TOK_W-1:0];
        CFG_REFILL_RATE:  cfg_nxt.refill_rate  = cfg_data[TOK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit_enable <= 1'b1;
      cfg_r.max_tokens   <= TOK_W'(20);
      cfg_r.refill_rate  <= TOK_W'(10);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ptbl_front #(
    .NUM_CATEGORIES (NUM_CATEGORIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg_r),
    .clr_busy  (clr_busy),
    .q_pop     (q_pop),
    .q_head    (q_head)
  );

  ptbl_back #(
    .NUM_CATEGORIES (NUM_CATEGORIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .clr_busy   (clr_busy),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_res    (res)
  );

  // Pack the result word
  assign out_tdata = {(OUT_TDATA_W - CAT_W - CNT_W)'(0), res.count, res.cat};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// ----- sim/per_category_token_bucket_limiter_test.sv -----
// Self-checking bench for the per-category token bucket limiter: directed and random messages.
`timescale 1ns / 100ps

module per_category_token_bucket_limiter_test;
  import ptbl_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int SHOW_LIMIT  = 40;

  typedef struct {
    logic [CAT_W-1:0]  cat;
    logic              has_cat;
    logic [TIME_W-1:0] now;
  } msg_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]      out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  per_category_token_bucket_limiter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the limiter: registers and bucket store
  logic             lim_en;
  logic [TOK_W-1:0] max_tok;
  logic [TOK_W-1:0] fill_rate;
  logic             bkt_valid  [NUM_CATEGORIES_DEF];
  logic [TOK_W-1:0] bkt_tokens [NUM_CATEGORIES_DEF];
  logic [TIME_W-1:0] bkt_stamp [NUM_CATEGORIES_DEF];
  logic [CNT_W-1:0] bkt_supp   [NUM_CATEGORIES_DEF];

  result_t expected_words[$];
  msg_t    pending_msgs[$];
  msg_t    cur_msg;
  logic    msg_live = 1'b0;
  int      queued_count   = 0;
  int      accepted_count = 0;
  int      err_count      = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  logic    hold_req       = 1'b0;
  int      hold_count     = 0;
  logic [TIME_W-1:0] sim_ms;

  function automatic void push_word(input logic [KIND_W-1:0] kind, input logic [CAT_W-1:0] cat,
                                    input logic [CNT_W-1:0] count, input logic last);
    result_t w;
    w.kind  = kind;
    w.cat   = cat;
    w.count = count;
    w.last  = last;
    expected_words.push_back(w);
  endfunction

  // Police one message against its bucket and queue the words it yields
  function automatic void police_message(input logic [CAT_W-1:0] cat, input logic has_cat,
                                         input logic [TIME_W-1:0] now);
    logic [63:0] tokens;
    logic [63:0] elapsed;
    logic [63:0] refill;
    if (!lim_en || !has_cat) begin
      push_word(KIND_PASS, cat, '0, 1'b1);
      return;
    end
    // first touch fills the bucket and stamps it
    if (!bkt_valid[cat]) begin
      bkt_valid[cat]  = 1'b1;
      bkt_stamp[cat]  = now;
      bkt_tokens[cat] = max_tok;
    end
    tokens = 64'(bkt_tokens[cat]);
    if (now > bkt_stamp[cat]) begin
      elapsed = 64'(now - bkt_stamp[cat]);
      refill  = (elapsed * 64'(fill_rate)) / 64'd1000;
      if (refill != 0) begin
        tokens = tokens + refill;
        if (tokens > 64'(max_tok)) begin
          tokens = 64'(max_tok);
        end
        bkt_stamp[cat] = now;
        if (bkt_supp[cat] != 0 && tokens != 0) begin
          push_word(KIND_SUMMARY, cat, bkt_supp[cat], 1'b0);
          bkt_supp[cat] = '0;
        end
      end
    end
    if (tokens != 0) begin
      tokens = tokens - 1;
      push_word(KIND_PASS, cat, '0, 1'b1);
    end else begin
      if (bkt_supp[cat] != CNT_MAX) begin
        bkt_supp[cat] = bkt_supp[cat] + 1;
      end
      push_word(KIND_DROP, cat, '0, 1'b1);
    end
    bkt_tokens[cat] = tokens[TOK_W-1:0];
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    err_count++;
    if (err_count <= SHOW_LIMIT) begin
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    end
  endtask

  // Feed pending messages onto the input stream; keep valid up until taken
  always @(posedge clk) begin : feed_driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        police_message(cur_msg.cat, cur_msg.has_cat, cur_msg.now);
        accepted_count++;
        msg_live = 1'b0;
      end
      if (!msg_live && pending_msgs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_msg  = pending_msgs.pop_front();
        msg_live = 1'b1;
      end
      in_tvalid <= msg_live;
      in_tdata  <= {2'b00, cur_msg.now, cur_msg.cat};
      in_tuser  <= cur_msg.has_cat;
    end
  end

  // Count down a long receiver hold-off once requested
  always @(posedge clk) begin : hold_off_timer
    if (!rst_n) begin
      hold_count <= 0;
    end else if (hold_req) begin
      hold_count <= HOLD_CYCLES;
    end else if (hold_count != 0) begin
      hold_count <= hold_count - 1;
    end
  end

  // Check each result word against the oldest expectation; throttle ready
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          flag_mismatch("result word with nothing expected", 64'(out_tdata), 64'd0);
        end else begin
          want = expected_words.pop_front();
          if (out_tuser !== want.kind)
            flag_mismatch("kind", 64'(out_tuser), 64'(want.kind));
          if (out_tdata[CAT_W-1:0] !== want.cat)
            flag_mismatch("category", 64'(out_tdata[CAT_W-1:0]), 64'(want.cat));
          if (out_tdata[CAT_W+CNT_W-1:CAT_W] !== want.count)
            flag_mismatch("suppressed count", 64'(out_tdata[CAT_W+CNT_W-1:CAT_W]),
                          64'(want.count));
          if (out_tlast !== want.last)
            flag_mismatch("last", 64'(out_tlast), 64'(want.last));
        end
      end
      out_tready <= (hold_count == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_msg(input logic [CAT_W-1:0] cat, input logic has_cat,
                           input logic [TIME_W-1:0] now);
    msg_t m;
    m.cat     = cat;
    m.has_cat = has_cat;
    m.now     = now;
    pending_msgs.push_back(m);
    queued_count++;
  endtask

  // Hold until every message is taken and every word has come back
  task automatic drain_all();
    while (accepted_count != queued_count || expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LIMIT_ENABLE: lim_en    = val[0];
      CFG_MAX_TOKENS:   max_tok   = val[TOK_W-1:0];
      CFG_REFILL_RATE:  fill_rate = val[TOK_W-1:0];
      default: ;
    endcase
  endtask

  // Random traffic: mostly a few busy categories on a forward-running clock
  task automatic queue_random(input int count);
    int               step_max;
    int               r;
    logic [CAT_W-1:0] cat;
    logic             has_cat;
    logic [TIME_W-1:0] now;
    step_max = 1500 / (fill_rate == 0 ? 1 : int'(fill_rate)) + 1;
    for (int n = 0; n < count; n++) begin
      cat     = ($urandom_range(99) < 70) ? CAT_W'($urandom_range(3)) : CAT_W'($urandom);
      has_cat = ($urandom_range(99) < 90);
      r       = $urandom_range(99);
      if (r < 3) begin
        now = {16'($urandom), 32'($urandom)};
      end else if (r < 10) begin
        now = (sim_ms > 600) ? sim_ms - TIME_W'($urandom_range(1, 500)) : sim_ms;
      end else if (r < 13) begin
        sim_ms = sim_ms + TIME_W'($urandom_range(1, 2_000_000));
        now    = sim_ms;
      end else begin
        sim_ms = sim_ms + TIME_W'($urandom_range(0, step_max));
        now    = sim_ms;
      end
      if (sim_ms > 48'hF000_0000_0000) sim_ms = 48'd20000;
      if (now == 0) now = 48'd1;
      queue_msg(cat, has_cat, now);
    end
  endtask

  initial begin : run_limit
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    lim_en    = 1'b1;
    max_tok   = 10'd20;
    fill_rate = 10'd10;
    sim_ms    = 48'd20000;
    for (int i = 0; i < NUM_CATEGORIES_DEF; i++) begin
      bkt_valid[i]  = 1'b0;
      bkt_tokens[i] = '0;
      bkt_stamp[i]  = '0;
      bkt_supp[i]   = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: bypass, first use at time extremes, time going backward
    queue_msg(6'd63, 1'b0, 48'hFFFF_FFFF_FFFF);
    queue_msg(6'd0,  1'b1, 48'd1);
    queue_msg(6'd63, 1'b1, 48'hFFFF_FFFF_FFFE);
    queue_msg(6'd63, 1'b1, 48'd1);
    queue_msg(6'd42, 1'b0, 48'h5555_5555_5555);
    queue_msg(6'd21, 1'b1, 48'hAAAA_AAAA_AAAA);
    drain_all();

    // Small bucket, fast refill: drain, drop, summary on refill, huge refill
    write_reg(CFG_MAX_TOKENS, 10'd3);
    write_reg(CFG_REFILL_RATE, 10'd1000);
    repeat (5) queue_msg(6'd5, 1'b1, 48'd1000);
    queue_msg(6'd5, 1'b1, 48'd999);
    queue_msg(6'd5, 1'b1, 48'd1001);
    queue_msg(6'd5, 1'b1, 48'hFFFF_FFFF_FFFF);
    queue_msg(6'd7, 1'b1, 48'd5000);
    drain_all();

    // Lowered capacity: tokens above the new ceiling are cut only on refill
    write_reg(CFG_MAX_TOKENS, 10'd1);
    queue_msg(6'd7, 1'b1, 48'd5000);
    queue_msg(6'd7, 1'b1, 48'd6000);
    queue_msg(6'd7, 1'b1, 48'd6000);
    drain_all();

    // Zero capacity drops everything and never summarizes
    write_reg(CFG_MAX_TOKENS, 10'd0);
    queue_msg(6'd9, 1'b1, 48'd10);
    queue_msg(6'd9, 1'b1, 48'd2000);
    drain_all();

    // Zero refill rate: buckets never refill
    write_reg(CFG_MAX_TOKENS, 10'd1);
    write_reg(CFG_REFILL_RATE, 10'd0);
    queue_msg(6'd11, 1'b1, 48'd10);
    queue_msg(6'd11, 1'b1, 48'd100000);
    drain_all();

    // Limiting off passes a drained bucket
    write_reg(CFG_LIMIT_ENABLE, 10'd0);
    queue_msg(6'd5, 1'b1, 48'd1);
    queue_msg(6'd9, 1'b1, 48'd3000);
    drain_all();

    // Random phase: no idling on either side
    write_reg(CFG_LIMIT_ENABLE, 10'd1);
    write_reg(CFG_MAX_TOKENS, 10'd4);
    write_reg(CFG_REFILL_RATE, 10'd50);
    queue_random(225);
    drain_all();

    // Random phase: widest bucket, fastest refill, sender mostly idle
    send_idle_pct = 82;
    write_reg(CFG_MAX_TOKENS, 10'd1023);
    write_reg(CFG_REFILL_RATE, 10'd1000);
    queue_random(225);
    drain_all();

    // Random phase: one-token bucket, slowest refill, receiver mostly stalled
    send_idle_pct  = 0;
    recv_stall_pct = 82;
    write_reg(CFG_MAX_TOKENS, 10'd1);
    write_reg(CFG_REFILL_RATE, 10'd1);
    queue_random(225);
    drain_all();

    // Random phase: random settings, light idling on both sides
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    write_reg(CFG_MAX_TOKENS, 10'($urandom_range(2, 12)));
    write_reg(CFG_REFILL_RATE, 10'($urandom_range(1, 1000)));
    queue_random(225);
    drain_all();

    // Back-pressure: hold the output off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(CFG_MAX_TOKENS, 10'd20);
    write_reg(CFG_REFILL_RATE, 10'd10);
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    queue_random(40);
    drain_all();

    repeat (20) @(posedge clk);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
